FILE: rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by the controller, the datapath, the top level and the checker.
package spq_pkg;

   // Result status codes.
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_LISTED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // Request kinds.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LIST   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;        // insert the request entry, or report full
      logic list_step;     // present the head entry and rotate the store
      logic report_empty;  // present the empty status
   } spq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;    // no entry stored
      logic at_last;  // the head entry is the final one of this listing
   } spq_sts_type;

endpackage

FILE: rtl/core/spq_ctrl.sv
// Controller of the sorted priority queue: accepts requests and sequences listings.
// Depends on spq_pkg for the command and status types.
module spq_ctrl
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        req_kind,
   input  spq_sts_type sts,
   output logic        busy,
   output spq_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LIST = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in         = state_ff;
      cmd.insert       = 1'b0;
      cmd.list_step    = 1'b0;
      cmd.report_empty = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_INSERT) begin
                  cmd.insert = 1'b1;
               end else if (sts.empty) begin
                  cmd.report_empty = 1'b1;
               end else begin
                  // The step for the first entry is issued in the same cycle the request is taken.
                  cmd.list_step = 1'b1;
                  if (!sts.at_last) begin
                     state_in = S_LIST;
                  end
               end
            end
         end
         S_LIST: begin
            cmd.list_step = 1'b1;
            if (sts.at_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/spq_datapath.sv
// Datapath of the sorted priority queue: the sorted register array, fill count,
// listing index and result registers. Depends on spq_pkg.
module spq_datapath
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  spq_cmd_type cmd,
   input  logic [7:0]  req_symbol,
   input  logic [7:0]  req_priority_req,
   output spq_sts_type sts,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_symbol,
   output logic [7:0]  rsp_out_priority,
   output logic        rsp_last
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   logic [7:0]    sym_ff [QUEUE_DEPTH];
   logic [7:0]    sym_in [QUEUE_DEPTH];
   logic [7:0]    pri_ff [QUEUE_DEPTH];
   logic [7:0]    pri_in [QUEUE_DEPTH];
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] fill_in;
   logic [CW-1:0] fill_last;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] idx_in;
   logic          full;

   // A slot is at or after the insertion point when it is unused or holds a
   // larger priority; this is monotonic because the store is sorted.
   logic [QUEUE_DEPTH-1:0] after;

   logic       strobe_ff;
   logic       strobe_in;
   logic [1:0] status_ff;
   logic [1:0] status_in;
   logic [7:0] osym_ff;
   logic [7:0] osym_in;
   logic [7:0] opri_ff;
   logic [7:0] opri_in;
   logic       last_ff;
   logic       last_in;

   assign full        = (fill_ff == CW'(QUEUE_DEPTH));
   assign fill_last   = fill_ff - CW'(1);
   assign sts.empty   = (fill_ff == '0);
   assign sts.at_last = (CW'(idx_ff) == fill_last);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         after[i] = (fill_ff <= CW'(i)) || (pri_ff[i] > req_priority_req);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sym_in[i] = sym_ff[i];
         pri_in[i] = pri_ff[i];
      end
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      osym_in   = osym_ff;
      opri_in   = opri_ff;
      last_in   = last_ff;

      if (cmd.insert) begin
         strobe_in = 1'b1;
         osym_in   = 8'd0;
         opri_in   = 8'd0;
         last_in   = 1'b1;
         if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERTED;
            fill_in   = fill_ff + CW'(1);
            if (after[0]) begin
               sym_in[0] = req_symbol;
               pri_in[0] = req_priority_req;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (after[i]) begin
                  if (after[i-1]) begin
                     sym_in[i] = sym_ff[i-1];
                     pri_in[i] = pri_ff[i-1];
                  end else begin
                     sym_in[i] = req_symbol;
                     pri_in[i] = req_priority_req;
                  end
               end
            end
         end
      end else if (cmd.report_empty) begin
         strobe_in = 1'b1;
         status_in = ST_EMPTY;
         osym_in   = 8'd0;
         opri_in   = 8'd0;
         last_in   = 1'b1;
      end else if (cmd.list_step) begin
         strobe_in = 1'b1;
         status_in = ST_LISTED;
         osym_in   = sym_ff[0];
         opri_in   = pri_ff[0];
         last_in   = sts.at_last;
         idx_in    = sts.at_last ? '0 : idx_ff + IW'(1);
         // Rotate the stored entries by one so the next one reaches the head.
         // After a full listing the original order is back in place.
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (CW'(i) == fill_last) begin
               sym_in[i] = sym_ff[0];
               pri_in[i] = pri_ff[0];
            end else begin
               sym_in[i] = sym_ff[i+1];
               pri_in[i] = pri_ff[i+1];
            end
         end
         sym_in[QUEUE_DEPTH-1] = sym_ff[0];
         pri_in[QUEUE_DEPTH-1] = pri_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sym_ff[i] <= sym_in[i];
         pri_ff[i] <= pri_in[i];
      end
      status_ff <= status_in;
      osym_ff   <= osym_in;
      opri_ff   <= opri_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_symbol   = osym_ff;
   assign rsp_out_priority = opri_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Holds up to QUEUE_DEPTH (symbol, priority) entries in ascending priority
// order, equal priorities in arrival order. A request is taken when start is
// high and busy is low. An insert is done in the cycle it is taken: all slots
// compare against the new priority in parallel and shift in one step, and its
// single status result shows on the next cycle. A list request produces one
// result per stored entry, one per cycle, starting the cycle after it is
// taken, or a single empty status when nothing is stored; the register array
// rotates one slot per result so the head slot always feeds the output. Busy
// stays high until the last listed result is registered, and a new request
// may be taken in the cycle that result is shown. Each result is valid for
// exactly one cycle with rsp_strobe high and must be captured then.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_kind,
   input  logic [7:0] req_symbol,
   input  logic [7:0] req_priority_req,
   output logic       rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_symbol,
   output logic [7:0] rsp_out_priority,
   output logic       rsp_last
);

   spq_cmd_type cmd;
   spq_sts_type sts;

   spq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   spq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_symbol       (req_symbol),
      .req_priority_req (req_priority_req),
      .sts              (sts),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_out_priority (rsp_out_priority),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg for the status codes.
module spq_checker
   import spq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_out_symbol,
   input logic [7:0] rsp_out_priority,
   input logic       rsp_last
);

   // Every accepted request answers in the very next cycle.
   a_answer_next: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe)
      else $error("accepted request produced no result on the next cycle");

   // A listing that is not finished keeps the block busy.
   a_busy_mid_list: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("block not busy while a listing is in progress");

   // A non-final result is followed at once by another listed entry.
   a_list_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && (rsp_status == ST_LISTED))
      else $error("listing transfer sequence broken");

   // Status-only results are single, final and carry no entry.
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_LISTED)
         |-> rsp_last && (rsp_out_symbol == 8'd0) && (rsp_out_priority == 8'd0))
      else $error("status result carries entry data or is not final");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_out_symbol   (rsp_out_symbol),
   .rsp_out_priority (rsp_out_priority),
   .rsp_last         (rsp_last)
);
